@@ rtl/scsi_rw_pkg.sv @@
// Shared types and constants for the SCSI READ/WRITE command check.
`default_nettype none

package scsi_rw_pkg;

  // Field widths
  localparam int LBA_W  = 64;
  localparam int CNT_W  = 32;
  localparam int HOST_W = 32;
  localparam int DISK_W = 55;
  localparam int MAXX_W = 32;
  localparam int LEN_W  = 5;

  // Opcodes
  localparam logic [7:0] OP_READ6   = 8'h08;
  localparam logic [7:0] OP_WRITE6  = 8'h0A;
  localparam logic [7:0] OP_READ10  = 8'h28;
  localparam logic [7:0] OP_WRITE10 = 8'h2A;
  localparam logic [7:0] OP_READ12  = 8'hA8;
  localparam logic [7:0] OP_WRITE12 = 8'hAA;
  localparam logic [7:0] OP_READ16  = 8'h88;
  localparam logic [7:0] OP_WRITE16 = 8'h8A;

  // Command lengths per form
  localparam logic [LEN_W-1:0] CDB_LEN6  = 5'd6;
  localparam logic [LEN_W-1:0] CDB_LEN10 = 5'd10;
  localparam logic [LEN_W-1:0] CDB_LEN12 = 5'd12;
  localparam logic [LEN_W-1:0] CDB_LEN16 = 5'd16;

  // 6-byte form: LBA bits in byte 1, zero length means 256 blocks
  localparam logic [4:0]       LBA6_MASK = 5'h1f;
  localparam logic [CNT_W-1:0] CNT6_ZERO = 32'd256;

  // Sense data
  localparam logic [3:0] SENSE_NONE      = 4'h0;
  localparam logic [3:0] SENSE_ILLEGAL   = 4'h5;
  localparam logic [7:0] ASC_NONE        = 8'h00;
  localparam logic [7:0] ASC_INVALID_CDB = 8'h24;
  localparam logic [7:0] ASC_LBA_RANGE   = 8'h21;

  typedef enum logic [1:0] {
    OUTCOME_XFER    = 2'd0,
    OUTCOME_NO_DATA = 2'd1,
    OUTCOME_CHECK   = 2'd2
  } outcome_t;

  // Decoded command, front to back
  typedef struct packed {
    logic              is_write;
    logic              dec_ok;
    logic [LBA_W-1:0]  lba;
    logic [CNT_W-1:0]  cnt;
    logic [HOST_W-1:0] host_bytes;
    logic              host_present;
  } cmd_t;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Configuration port
  localparam int CFG_ADDR_W  = 4;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_BIT = 3;
  localparam logic REG_DISK_BLOCKS = 1'b0;
  localparam logic REG_MAX_XFER    = 1'b1;
  localparam logic [MAXX_W-1:0] MAX_XFER_RESET = 32'd1048576;

endpackage

`default_nettype wire

@@ rtl/scsi_rw_ifs.sv @@
// Valid/ready channel interfaces for commands and results.
`default_nettype none

interface scsi_rw_cmd_if;
  import scsi_rw_pkg::*;
  logic              valid;
  logic              ready;
  logic [63:0]       cdb_head;
  logic [63:0]       cdb_tail;
  logic [LEN_W-1:0]  cdb_bytes;
  logic [HOST_W-1:0] host_buffer_bytes;
  logic              host_buffer_present;

  modport source (output valid, cdb_head, cdb_tail, cdb_bytes, host_buffer_bytes,
                  host_buffer_present, input ready);
  modport sink   (input valid, cdb_head, cdb_tail, cdb_bytes, host_buffer_bytes,
                  host_buffer_present, output ready);
endinterface

interface scsi_rw_rsp_if;
  import scsi_rw_pkg::*;
  logic             valid;
  logic             ready;
  outcome_t         outcome;
  logic [3:0]       sense_key;
  logic [7:0]       sense_code;
  logic             is_write;
  logic [LBA_W-1:0] start_block;
  logic [CNT_W-1:0] block_total;
  logic [63:0]      byte_offset;
  logic [31:0]      byte_total;

  modport source (output valid, outcome, sense_key, sense_code, is_write, start_block,
                  block_total, byte_offset, byte_total, input ready);
  modport sink   (input valid, outcome, sense_key, sense_code, is_write, start_block,
                  block_total, byte_offset, byte_total, output ready);
endinterface

`default_nettype wire

@@ rtl/scsi_rw_front.sv @@
// Front end: accepts a command and decodes opcode, LBA and block count.
`default_nettype none

module scsi_rw_front (
  input  wire logic               clk,
  input  wire logic               rst,
  scsi_rw_cmd_if.sink             cmd,
  output logic                    q_valid,
  output scsi_rw_pkg::cmd_t       q_data,
  input  wire logic               q_ready
);
  import scsi_rw_pkg::*;

  logic [7:0]       op;
  logic [63:0]      head;
  logic [63:0]      tail;
  logic             known;
  logic [LEN_W-1:0] need;
  logic [LBA_W-1:0] lba;
  logic [CNT_W-1:0] cnt;
  cmd_t             dec;
  logic             fr_valid;
  cmd_t             fr_data;

  always_comb begin
    head  = cmd.cdb_head;
    tail  = cmd.cdb_tail;
    op    = head[63:56];
    known = 1'b1;
    need  = CDB_LEN6;
    lba   = '0;
    cnt   = '0;
    unique case (op)
      OP_READ6, OP_WRITE6: begin
        need = CDB_LEN6;
        lba  = LBA_W'({head[52:48] & LBA6_MASK, head[47:32]});
        cnt  = (head[31:24] == 8'd0) ? CNT6_ZERO : CNT_W'(head[31:24]);
      end
      OP_READ10, OP_WRITE10: begin
        need = CDB_LEN10;
        lba  = LBA_W'(head[47:16]);
        cnt  = CNT_W'({head[7:0], tail[63:56]});
      end
      OP_READ12, OP_WRITE12: begin
        need = CDB_LEN12;
        lba  = LBA_W'(head[47:16]);
        cnt  = {head[15:0], tail[63:48]};
      end
      OP_READ16, OP_WRITE16: begin
        need = CDB_LEN16;
        lba  = {head[47:0], tail[63:48]};
        cnt  = tail[47:16];
      end
      default: begin
        known = 1'b0;
      end
    endcase

    dec.is_write     = (op == OP_WRITE6) || (op == OP_WRITE10) ||
                       (op == OP_WRITE12) || (op == OP_WRITE16);
    dec.dec_ok       = known && (cmd.cdb_bytes >= need);
    dec.lba          = dec.dec_ok ? lba : '0;
    dec.cnt          = dec.dec_ok ? cnt : '0;
    dec.host_bytes   = cmd.host_buffer_bytes;
    dec.host_present = cmd.host_buffer_present;
  end

  assign cmd.ready = !fr_valid || q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
    end else if (cmd.ready) begin
      fr_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      fr_data <= dec;
    end
  end

  assign q_valid = fr_valid;
  assign q_data  = fr_data;

endmodule

`default_nettype wire

@@ rtl/scsi_rw_queue.sv @@
// Short queue of decoded commands between front and back end.
`default_nettype none

module scsi_rw_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire scsi_rw_pkg::cmd_t  in_data,
  output logic                    in_ready,
  output logic                    out_valid,
  output scsi_rw_pkg::cmd_t       out_data,
  input  wire logic               out_ready
);
  import scsi_rw_pkg::*;

  cmd_t                   mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic                   push;
  logic                   pop;

  assign in_ready  = (count != QUEUE_CNT_W'(QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_data;
    end
  end

endmodule

`default_nettype wire

@@ rtl/scsi_rw_back.sv @@
// Back end: range check, byte count checks and result register.
`default_nettype none

module scsi_rw_back #(
  parameter int SECTOR_BYTES = 512
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  input  wire scsi_rw_pkg::cmd_t            in_data,
  output logic                              in_ready,
  input  wire logic [scsi_rw_pkg::DISK_W-1:0] disk_blocks,
  input  wire logic [scsi_rw_pkg::MAXX_W-1:0] max_transfer_bytes,
  scsi_rw_rsp_if.source                     rsp
);
  import scsi_rw_pkg::*;

  localparam int SEC_W   = $clog2(SECTOR_BYTES + 1);
  localparam int BYTES_W = CNT_W + SEC_W;
  localparam logic [SEC_W-1:0] SEC = SEC_W'(SECTOR_BYTES);

  // Stage A: range sum/compare and sector multiplies
  logic [LBA_W:0]     end_sum;
  logic               in_range;
  logic [BYTES_W-1:0] bytes_prod;
  logic [BYTES_W-1:0] off_lo_prod;
  logic [BYTES_W-1:0] off_hi_prod;

  logic               a_valid;
  logic               a_ready;
  cmd_t               a_cmd;
  logic               a_cnt_zero;
  logic               a_in_range;
  logic [BYTES_W-1:0] a_bytes;
  logic [BYTES_W-1:0] a_off_lo;
  logic [BYTES_W-1:0] a_off_hi;

  // Stage B: byte checks and result
  logic               b_ready;
  logic [CNT_W-1:0]   bytes32;
  logic               bytes_ok;
  logic [63:0]        offset;

  // lba + cnt > disk covers both lba >= disk and cnt > disk - lba
  assign end_sum     = {1'b0, in_data.lba} + (LBA_W + 1)'(in_data.cnt);
  assign in_range    = (end_sum <= (LBA_W + 1)'(disk_blocks));
  assign bytes_prod  = BYTES_W'(in_data.cnt) * BYTES_W'(SEC);
  assign off_lo_prod = BYTES_W'(in_data.lba[31:0]) * BYTES_W'(SEC);
  assign off_hi_prod = BYTES_W'(in_data.lba[63:32]) * BYTES_W'(SEC);

  assign b_ready  = !rsp.valid || rsp.ready;
  assign a_ready  = !a_valid || b_ready;
  assign in_ready = a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && a_ready) begin
      a_cmd      <= in_data;
      a_cnt_zero <= (in_data.cnt == '0);
      a_in_range <= in_range;
      a_bytes    <= bytes_prod;
      a_off_lo   <= off_lo_prod;
      a_off_hi   <= off_hi_prod;
    end
  end

  assign bytes32  = a_bytes[CNT_W-1:0];
  assign bytes_ok = (a_bytes[BYTES_W-1:CNT_W] == '0) &&
                    (bytes32 <= max_transfer_bytes) &&
                    (a_cmd.host_bytes >= bytes32) &&
                    a_cmd.host_present;
  // product modulo 2^64
  assign offset   = {a_off_hi[31:0], 32'd0} + 64'(a_off_lo);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (b_ready) begin
      rsp.valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid && b_ready) begin
      rsp.is_write    <= a_cmd.is_write;
      rsp.start_block <= a_cmd.lba;
      rsp.block_total <= a_cmd.cnt;
      rsp.byte_offset <= '0;
      rsp.byte_total  <= '0;
      priority if (!a_cmd.dec_ok) begin
        rsp.outcome    <= OUTCOME_CHECK;
        rsp.sense_key  <= SENSE_ILLEGAL;
        rsp.sense_code <= ASC_INVALID_CDB;
      end else if (a_cnt_zero) begin
        rsp.outcome    <= OUTCOME_NO_DATA;
        rsp.sense_key  <= SENSE_NONE;
        rsp.sense_code <= ASC_NONE;
      end else if (!a_in_range) begin
        rsp.outcome    <= OUTCOME_CHECK;
        rsp.sense_key  <= SENSE_ILLEGAL;
        rsp.sense_code <= ASC_LBA_RANGE;
      end else if (bytes_ok) begin
        rsp.outcome     <= OUTCOME_XFER;
        rsp.sense_key   <= SENSE_NONE;
        rsp.sense_code  <= ASC_NONE;
        rsp.byte_offset <= offset;
        rsp.byte_total  <= bytes32;
      end else begin
        rsp.outcome    <= OUTCOME_CHECK;
        rsp.sense_key  <= SENSE_ILLEGAL;
        rsp.sense_code <= ASC_INVALID_CDB;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_data_zero_cnt: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.outcome == OUTCOME_NO_DATA) |-> (rsp.block_total == '0))
    else $error("no-data outcome with nonzero block count");

  a_xfer_within_limit: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.outcome == OUTCOME_XFER) |->
      (rsp.byte_total != '0) && (rsp.byte_total <= max_transfer_bytes))
    else $error("transfer byte count outside limit");

  a_bytes_only_on_xfer: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.outcome != OUTCOME_XFER) |->
      (rsp.byte_total == '0) && (rsp.byte_offset == '0))
    else $error("byte fields set without transfer");

  a_sense_matches_outcome: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> ((rsp.outcome == OUTCOME_CHECK) == (rsp.sense_key == SENSE_ILLEGAL)))
    else $error("sense key disagrees with outcome");
`endif

endmodule

`default_nettype wire

@@ rtl/scsi_read_write_cdb_check_unit.sv @@
// Top level of the SCSI READ/WRITE command check with its register port.
//
//  channel  dir  handshake      payload
//  cmd      in   valid/ready    cdb_head, cdb_tail, cdb_bytes, host_buffer_*
//  rsp      out  valid/ready    outcome, sense, is_write, start/total, byte_*
//  apb      in   psel/penable   disk_blocks @0x0, max_transfer_bytes @0x8
//
// One transaction per cycle sustained while rsp is ready; a command passes the decode
// register, queue entry, range/multiply stage and result register before rsp valid.
// rst is synchronous: pipeline and queue empty, disk_blocks 0,
// max_transfer_bytes 1 MiB. A stall on rsp backs up through the back end;
// the two-entry queue keeps the front accepting until it fills.
`default_nettype none

module scsi_read_write_cdb_check_unit #(
  parameter int SECTOR_BYTES = 512
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  scsi_rw_cmd_if.sink                            cmd,
  scsi_rw_rsp_if.source                          rsp,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [scsi_rw_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [scsi_rw_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [scsi_rw_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                   pready
);
  import scsi_rw_pkg::*;

  // Configuration registers
  logic [DISK_W-1:0] disk_blocks;
  logic [MAXX_W-1:0] max_transfer_bytes;
  logic              cfg_write;
  logic              reg_sel;

  // Front -> queue -> back
  logic fr_valid;
  cmd_t fr_data;
  logic fr_ready;
  logic bk_valid;
  cmd_t bk_data;
  logic bk_ready;

  assign pready    = 1'b1;
  assign reg_sel   = paddr[CFG_IDX_BIT];   // registers on 8-byte boundaries
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      disk_blocks        <= '0;
      max_transfer_bytes <= MAX_XFER_RESET;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_DISK_BLOCKS: disk_blocks        <= pwdata[DISK_W-1:0];
        REG_MAX_XFER:    max_transfer_bytes <= pwdata[MAXX_W-1:0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_DISK_BLOCKS: prdata = CFG_DATA_W'(disk_blocks);
      REG_MAX_XFER:    prdata = CFG_DATA_W'(max_transfer_bytes);
      default:         prdata = '0;
    endcase
  end

  // Decode: opcode, form length check, LBA/count extraction
  scsi_rw_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .q_valid (fr_valid),
    .q_data  (fr_data),
    .q_ready (fr_ready)
  );

  // Decouples decode from the checking pipeline
  scsi_rw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .in_data   (fr_data),
    .in_ready  (fr_ready),
    .out_valid (bk_valid),
    .out_data  (bk_data),
    .out_ready (bk_ready)
  );

  // Capacity and transfer checks, result register
  scsi_rw_back #(
    .SECTOR_BYTES (SECTOR_BYTES)
  ) u_back (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (bk_valid),
    .in_data            (bk_data),
    .in_ready           (bk_ready),
    .disk_blocks        (disk_blocks),
    .max_transfer_bytes (max_transfer_bytes),
    .rsp                (rsp)
  );

endmodule

`default_nettype wire
